// ===== rtl/lota_pkg.sv =====
package lota_pkg;

	// field widths
	localparam int SF_W   = 4;
	localparam int BW_W   = 2;
	localparam int LEN_W  = 8;
	localparam int AIR_W  = 13;
	localparam int QUO_W  = 10;
	localparam int RCP_W  = 13;

	// bandwidth codes, anything else runs at 125 kHz
	localparam logic [BW_W-1:0] BW_250 = 2'd1;
	localparam logic [BW_W-1:0] BW_500 = 2'd2;

	// low data rate optimization kicks in from this spreading factor
	localparam logic [SF_W-1:0] SF_LDRO = 4'd11;

	// reciprocal of 125 scaled by 2^24, and the point where the ms count clips
	localparam int              RCP125_SHIFT = 24;
	localparam logic [17:0]     RCP125       = 18'd134217;
	localparam logic [28:0]     SAT_LIMIT    = 29'd4095500;
	localparam logic [AIR_W-1:0] AIR_MAX     = 13'h1fff;

	// symbol group count handed from the divider to the scaler
	typedef struct packed {
		logic [SF_W-1:0]  sf;
		logic [BW_W-1:0]  bw_code;
		logic [QUO_W-1:0] quo;
	} lota_sym_t;

	// floor(4096 / d) for the divisors that occur, d = 1..13
	function automatic logic [RCP_W-1:0] lota_recip(input logic [3:0] d);
		logic [RCP_W-1:0] r;
		case (d)
			4'd2:    r = 13'd2048;
			4'd3:    r = 13'd1365;
			4'd4:    r = 13'd1024;
			4'd5:    r = 13'd819;
			4'd6:    r = 13'd682;
			4'd7:    r = 13'd585;
			4'd8:    r = 13'd512;
			4'd9:    r = 13'd455;
			4'd10:   r = 13'd409;
			4'd11:   r = 13'd372;
			4'd12:   r = 13'd341;
			4'd13:   r = 13'd315;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lora_time_on_air_unit.sv =====
// lora packet airtime calculator
// input channel: in_valid / in_stall carry one frame description per beat:
//   spread_factor, bandwidth_code (0=125, 1=250, 2=500 kHz, 3 as 125 kHz)
//   and payload_bytes; a beat is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall carry airtime_ms, the time on air in
//   whole milliseconds rounded up, clipped at 8191
// throughput: one beat per cycle, every cycle, with no stall downstream
// pipeline: seven register stages; three do the symbol count division by reciprocal
//   and correction, four scale by 2^sf and divide by the bandwidth, the last of them
//   being the output register
// stall: the whole pipe holds while out_valid is high and out_stall is high;
//   in_stall follows that condition, so nothing is dropped or repeated and a
//   new beat still enters while an empty output slot is being filled
// reset: arst_n clears every valid bit at once; no state is kept between
//   beats, so the block accepts right after reset
module lora_time_on_air_unit
	import lota_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SF_W-1:0]  spread_factor,
	input  logic [BW_W-1:0]  bandwidth_code,
	input  logic [LEN_W-1:0] payload_bytes,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [AIR_W-1:0] airtime_ms
);

	logic      en;
	logic      sym_valid;
	lota_sym_t sym;

	// pipe advances unless a result is waiting on a stalled receiver
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	lota_symbol_div u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (in_valid),
		.spread_factor  (spread_factor),
		.bandwidth_code (bandwidth_code),
		.payload_bytes  (payload_bytes),
		.valid_s3       (sym_valid),
		.sym_s3         (sym)
	);

	lota_airtime_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.sym_valid  (sym_valid),
		.sym        (sym),
		.out_valid  (out_valid),
		.airtime_ms (airtime_ms)
	);

endmodule

// ===== rtl/lota_symbol_div.sv =====
module lota_symbol_div
	import lota_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SF_W-1:0]  spread_factor,
	input  logic [BW_W-1:0]  bandwidth_code,
	input  logic [LEN_W-1:0] payload_bytes,
	output logic             valid_s3,
	output lota_sym_t        sym_s3
);

	logic signed [10:0] num_c;
	logic [3:0]         den_c;
	logic [QUO_W-1:0]   dvd_c;

	logic               valid_s1, valid_s2;
	logic [SF_W-1:0]    sf_s1, sf_s2;
	logic [BW_W-1:0]    bw_s1, bw_s2;
	logic [QUO_W-1:0]   dvd_s1, dvd_s2;
	logic [3:0]         den_s1, den_s2;
	logic [RCP_W-1:0]   rcp_s1;
	logic [QUO_W-1:0]   qest_s2;

	logic [22:0]        qprod_c;
	logic [13:0]        qd_c;
	logic [QUO_W-1:0]   rem_c;
	logic [QUO_W-1:0]   quo_c;

	// numerator and divisor, both divided by four; ceiling folded into the dividend
	always_comb begin
		num_c = $signed({2'b00, payload_bytes, 1'b0}) - $signed({7'd0, spread_factor})
			+ 11'sd11;
		if (spread_factor >= SF_LDRO) begin
			den_c = spread_factor - 4'd2;
		end else if (spread_factor == 4'd0) begin
			den_c = 4'd1;
		end else begin
			den_c = spread_factor;
		end
		if (num_c > 11'sd0) begin
			dvd_c = num_c[QUO_W-1:0] + {6'd0, den_c} - 10'd1;
		end else begin
			dvd_c = '0;
		end
	end

	// stage 1: operands and reciprocal lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sf_s1  <= spread_factor;
			bw_s1  <= bandwidth_code;
			dvd_s1 <= dvd_c;
			den_s1 <= den_c;
			rcp_s1 <= lota_recip(den_c);
		end
	end

	// stage 2: quotient estimate, low by at most one
	assign qprod_c = {13'd0, dvd_s1} * {10'd0, rcp_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sf_s2   <= sf_s1;
			bw_s2   <= bw_s1;
			dvd_s2  <= dvd_s1;
			den_s2  <= den_s1;
			qest_s2 <= qprod_c[21:12];
		end
	end

	// stage 3: remainder check corrects the estimate
	always_comb begin
		qd_c  = {4'd0, qest_s2} * {10'd0, den_s2};
		rem_c = dvd_s2 - qd_c[QUO_W-1:0];
		quo_c = qest_s2 + ((rem_c >= {6'd0, den_s2}) ? 10'd1 : 10'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sym_s3.sf      <= sf_s2;
			sym_s3.bw_code <= bw_s2;
			sym_s3.quo     <= quo_c;
		end
	end

endmodule

// ===== rtl/lota_airtime_scale.sv =====
module lota_airtime_scale
	import lota_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             sym_valid,
	input  lota_sym_t        sym,
	output logic             out_valid,
	output logic [AIR_W-1:0] airtime_ms
);

	logic [6:0]       gmul_c;
	logic [15:0]      sym4_c;
	logic [28:0]      chips_c;
	logic [1:0]       bsh_c;
	logic [29:0]      rsum_c;
	logic [21:0]      wsum_c;
	logic [37:0]      mprod_c;
	logic [19:0]      qm_c;
	logic [19:0]      rem_c;

	logic             valid_s4, valid_s5, valid_s6;
	logic [28:0]      y_s4;
	logic             sat_s5, sat_s6;
	logic [19:0]      w_s5, w_s6;
	logic [AIR_W-1:0] qe_s6;

	// stage 4: 49 + 4*symbols, times 2^sf, then ceiling shift for the bandwidth
	// at sf 0 the real divisor is one, not four, so each quotient step is four groups
	always_comb begin
		gmul_c  = (sym.sf == 4'd0) ? 7'd80 : 7'd20;
		sym4_c  = 16'd81 + ({6'd0, sym.quo} * {9'd0, gmul_c});
		chips_c = {13'd0, sym4_c} << sym.sf;
		if (sym.bw_code == BW_250) begin
			bsh_c = 2'd1;
		end else if (sym.bw_code == BW_500) begin
			bsh_c = 2'd2;
		end else begin
			bsh_c = 2'd0;
		end
		rsum_c = ({1'b0, chips_c} + ((30'd1 << bsh_c) - 30'd1)) >> bsh_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sym_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s4 <= rsum_c[28:0];
		end
	end

	// stage 5: clip check and ceiling offset, divide by 4 of the 500
	assign wsum_c = y_s4[21:0] + 22'd499;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s5 <= (y_s4 > SAT_LIMIT);
			w_s5   <= wsum_c[21:2];
		end
	end

	// stage 6: divide by 125 through the scaled reciprocal
	assign mprod_c = {18'd0, w_s5} * {20'd0, RCP125};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s6 <= sat_s5;
			w_s6   <= w_s5;
			qe_s6  <= mprod_c[RCP125_SHIFT+AIR_W-1:RCP125_SHIFT];
		end
	end

	// stage 7: correct the estimate, clip, output register
	always_comb begin
		qm_c  = {7'd0, qe_s6} * 20'd125;
		rem_c = w_s6 - qm_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s6) begin
				airtime_ms <= AIR_MAX;
			end else begin
				airtime_ms <= qe_s6 + ((rem_c >= 20'd125) ? 13'd1 : 13'd0);
			end
		end
	end

endmodule

// ===== rtl/lota_checker.sv =====
module lota_checker
	import lota_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [SF_W-1:0]  spread_factor,
	input logic [BW_W-1:0]  bandwidth_code,
	input logic [LEN_W-1:0] payload_bytes,
	input logic             out_valid,
	input logic             out_stall,
	input logic [AIR_W-1:0] airtime_ms
);

	// a held input beat keeps its value
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid
			&& $stable({spread_factor, bandwidth_code, payload_bytes}))
		else $error("input beat changed while stalled");

	// a held result beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(airtime_ms))
		else $error("result beat changed while stalled");

	// input only backs up when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with a free output");

	// every frame takes at least one millisecond
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> airtime_ms != '0)
		else $error("zero airtime delivered");

	// reset empties the pipe
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind lora_time_on_air_unit lota_checker u_lota_checker (.*);

// ===== dv/tb_lora_time_on_air_unit.sv =====
module tb_lora_time_on_air_unit;
	import lota_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_COUNT = 650;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	// bandwidth codes the package leaves unnamed
	localparam logic [BW_W-1:0] BW_125 = 2'd0;
	localparam logic [BW_W-1:0] BW_SPARE = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		logic [SF_W-1:0]  sf;
		logic [BW_W-1:0]  bw;
		logic [LEN_W-1:0] len;
		bit               known;
		logic [AIR_W-1:0] airtime;
	} frame_row_t;

	localparam int ROW_COUNT = 22;

	// directed frames; airtime typed in only where it is obvious
	frame_row_t frame_plan [ROW_COUNT] = '{
		'{4'd5,  BW_500,   8'd0,   1'b1, 13'd2},
		'{4'd11, BW_125,   8'd255, 1'b1, 13'd5002},
		'{4'd15, BW_125,   8'd255, 1'b1, 13'd8191},
		'{4'd0,  BW_500,   8'd0,   1'b1, 13'd1},
		'{4'd12, BW_125,   8'd0,   1'b1, 13'd664},
		'{4'd0,  BW_125,   8'd255, 1'b0, 13'd0},
		'{4'd1,  BW_250,   8'd1,   1'b0, 13'd0},
		'{4'd2,  BW_SPARE, 8'd128, 1'b0, 13'd0},
		'{4'd3,  BW_500,   8'd255, 1'b0, 13'd0},
		'{4'd4,  BW_125,   8'd0,   1'b0, 13'd0},
		'{4'd5,  BW_125,   8'd255, 1'b0, 13'd0},
		'{4'd6,  BW_250,   8'd17,  1'b0, 13'd0},
		'{4'd7,  BW_250,   8'd170, 1'b0, 13'd0},
		'{4'd8,  BW_125,   8'd85,  1'b0, 13'd0},
		'{4'd9,  BW_SPARE, 8'd64,  1'b0, 13'd0},
		'{4'd10, BW_500,   8'd255, 1'b0, 13'd0},
		'{4'd11, BW_SPARE, 8'd1,   1'b0, 13'd0},
		'{4'd11, BW_500,   8'd0,   1'b0, 13'd0},
		'{4'd13, BW_250,   8'd0,   1'b0, 13'd0},
		'{4'd14, BW_500,   8'd128, 1'b0, 13'd0},
		'{4'd15, BW_SPARE, 8'd0,   1'b0, 13'd0},
		'{4'd12, BW_250,   8'd255, 1'b0, 13'd0}
	};

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [SF_W-1:0]  spread_factor;
	logic [BW_W-1:0]  bandwidth_code;
	logic [LEN_W-1:0] payload_bytes;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [AIR_W-1:0] airtime_ms;

	logic [AIR_W-1:0] airtime_due [$];
	int               mismatches = 0;
	int               cycle_count = 0;
	stall_mode_t      stall_mode = STALL_NONE;
	int               stall_left = 0;

	lora_time_on_air_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.spread_factor  (spread_factor),
		.bandwidth_code (bandwidth_code),
		.payload_bytes  (payload_bytes),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.airtime_ms     (airtime_ms)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// airtime in ms, rounded up and clipped
	function automatic logic [AIR_W-1:0] airtime_of(input logic [SF_W-1:0] sf,
			input logic [BW_W-1:0] bw, input logic [LEN_W-1:0] len);
		int                khz;
		int                ldro;
		int                num;
		int                den;
		int                groups;
		longint unsigned   symbols;
		longint unsigned   chips;
		longint unsigned   span;
		longint unsigned   ms;
		case (bw)
			BW_250:  khz = 250;
			BW_500:  khz = 500;
			default: khz = 125;
		endcase
		ldro = (sf >= SF_LDRO) ? 1 : 0;
		num = 8 * int'(len) - 4 * int'(sf) + 44;
		den = 4 * (int'(sf) - 2 * ldro);
		// zero divisor only at sf 0
		if (den == 0)
			den = 1;
		groups = (num > 0) ? (num + den - 1) / den : 0;
		symbols = 8 + 5 * longint'(groups);
		chips = (49 + 4 * symbols) << sf;
		span = 4 * longint'(khz);
		ms = (chips + span - 1) / span;
		return (ms > AIR_MAX) ? AIR_MAX : ms[AIR_W-1:0];
	endfunction

	// one beat in, expectation queued at the accepting edge
	task automatic drive_frame(input logic [SF_W-1:0] sf, input logic [BW_W-1:0] bw,
			input logic [LEN_W-1:0] len, input logic [AIR_W-1:0] want);
		in_valid <= 1'b1;
		spread_factor <= sf;
		bandwidth_code <= bw;
		payload_bytes <= len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		airtime_due.push_back(want);
	endtask

	// gap between bursts, sometimes none
	task automatic idle_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver stall pattern, the mode is redrawn whenever its countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_left[2];
		endcase
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (airtime_due.size() == 0) begin
				$display("%0t: airtime_ms %0d with no beat outstanding", $time, airtime_ms);
				mismatches++;
			end else begin
				logic [AIR_W-1:0] want;
				want = airtime_due.pop_front();
				if (airtime_ms !== want) begin
					$display("%0t: airtime_ms expected %0d, actual %0d",
						$time, want, airtime_ms);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[lora_time_on_air_unit] ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		int               sent;
		int               burst;
		logic [SF_W-1:0]  sf;
		logic [BW_W-1:0]  bw;
		logic [LEN_W-1:0] len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		spread_factor = '0;
		bandwidth_code = '0;
		payload_bytes = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, with a short burst pattern
		for (int i = 0; i < ROW_COUNT; i++) begin
			drive_frame(frame_plan[i].sf, frame_plan[i].bw, frame_plan[i].len,
				frame_plan[i].known ? frame_plan[i].airtime
					: airtime_of(frame_plan[i].sf, frame_plan[i].bw, frame_plan[i].len));
			if (i % 5 == 4)
				idle_gap();
		end

		// random frames in bursts
		sent = 0;
		while (sent < FRAME_COUNT) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < FRAME_COUNT; k++) begin
				if ($urandom_range(0, 6) == 0)
					sf = SF_W'($urandom_range(0, 15));
				else
					sf = SF_W'($urandom_range(5, 11));
				if ($urandom_range(0, 9) == 0)
					bw = BW_SPARE;
				else
					bw = BW_W'($urandom_range(0, 2));
				case ($urandom_range(0, 9))
					0:       len = '0;
					1:       len = '1;
					default: len = LEN_W'($urandom_range(0, 255));
				endcase
				drive_frame(sf, bw, len, airtime_of(sf, bw, len));
				sent++;
			end
			idle_gap();
		end
		in_valid <= 1'b0;

		// drain
		while (airtime_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[lora_time_on_air_unit] OK");
		else
			$display("[lora_time_on_air_unit] ERROR");
		$finish;
	end

endmodule

// ===== lora_time_on_air_unit.f =====
rtl/lota_pkg.sv
rtl/lota_symbol_div.sv
rtl/lota_airtime_scale.sv
rtl/lora_time_on_air_unit.sv
rtl/lota_checker.sv
dv/tb_lora_time_on_air_unit.sv
